>>> src/pve_pkg.sv
`default_nettype none
package pve_pkg;

  localparam int SqSteps = 32;
  localparam int BdSteps = 18;
  localparam int DvSteps = 30;

  typedef enum logic [1:0] {
    OP_CIRCLE = 2'd0,
    OP_SQUARE = 2'd1,
    OP_LINE   = 2'd2,
    OP_BOX    = 2'd3
  } op_t;

  localparam logic KIND_QUAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam logic [3:0] CORNER_U = 4'b0110;
  localparam logic [3:0] CORNER_V = 4'b0011;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [30:0]        ext;
    logic [30:0]        thick;
    logic [31:0]        color;
  } in_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] p0x;
    logic signed [31:0] p0y;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic [31:0]        rad;
    logic               zero;
    logic               negx;
    logic               negy;
    logic [31:0]        color;
  } prim_t;

  typedef struct packed {
    prim_t       p;
    logic [32:0] a;
    logic [32:0] b;
    logic [29:0] h;
    logic [32:0] r2;
    logic [30:0] thick;
  } s1_t;

  typedef struct packed {
    prim_t       p;
    logic [32:0] a;
    logic [32:0] b;
    logic [32:0] m;
    logic [29:0] h;
    logic [32:0] r2;
    logic [30:0] thick;
  } s2_t;

  typedef struct packed {
    prim_t       p;
    logic [32:0] a;
    logic [32:0] b;
    logic [5:0]  e;
    logic [29:0] h;
    logic [32:0] r2;
    logic [30:0] thick;
  } s3_t;

  typedef struct packed {
    prim_t       p;
    logic [30:0] an;
    logic [30:0] bn;
    logic [29:0] h;
    logic [32:0] r2;
    logic [30:0] thick;
  } s4_t;

  typedef struct packed {
    prim_t       p;
    logic [61:0] sa;
    logic [61:0] sb;
    logic [60:0] na;
    logic [60:0] nb;
    logic [32:0] r2;
    logic [30:0] thick;
  } s5_t;

  typedef struct packed {
    prim_t       p;
    logic [63:0] s;
    logic [63:0] res;
    logic [60:0] na;
    logic [60:0] nb;
    logic [47:0] brem;
    logic [32:0] bden;
    logic [17:0] bq;
  } sq_t;

  typedef struct packed {
    prim_t       p;
    logic [31:0] len;
    logic [60:0] ra;
    logic [60:0] rb;
    logic [29:0] qa;
    logic [29:0] qb;
    logic [17:0] border;
  } dv_t;

  typedef struct packed {
    prim_t              p;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [17:0]        border;
  } em_t;

endpackage
`default_nettype wire

>>> src/primitive_to_vertex_expander.sv
`default_nettype none
// Expands each primitive beat into corner vertex beats, one vertex per cycle at the output
// while vert_stall is low. A circle, square or zero-length line gives 4 vertices, a line 12,
// a box 48 (16 when its size is below one LSB pair); the single vertex emitter sets the rate.
// A primitive passes through 70 register stages first: front calculation, normalisation,
// squares, a 32-stage bit-per-stage square root (which also carries the 18-stage circle
// border division) and a 30-stage bit-per-stage divider. While the emitter is busy the whole
// pipeline holds, so the input register takes a new primitive only when it is empty; the
// output register holds a stalled vertex.
module primitive_to_vertex_expander import pve_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               prim_valid,
  output logic                    prim_stall,
  input  wire logic [1:0]         operation,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic [30:0]        extent,
  input  wire logic [30:0]        thickness,
  input  wire logic [31:0]        color,
  output logic                    vert_valid,
  input  wire logic               vert_stall,
  output logic                    vertex_kind,
  output logic signed [31:0]      vertex_x,
  output logic signed [31:0]      vertex_y,
  output logic                    tex_u,
  output logic                    tex_v,
  output logic [31:0]             vertex_color,
  output logic [17:0]             border_ratio,
  output logic                    last
);

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t d, input int k);
    sq_t         o;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [50:0] bt;
    o     = d;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = d.res + bitv;
    if (d.s >= trial) begin
      o.s   = d.s - trial;
      o.res = (d.res >> 1) + bitv;
    end else begin
      o.res = d.res >> 1;
    end
    if (k < BdSteps) begin
      bt = {18'b0, d.bden} << (BdSteps - 1 - k);
      if ({3'b0, d.brem} >= bt) begin
        o.brem = d.brem - bt[47:0];
        o.bq   = d.bq | (18'd1 << (BdSteps - 1 - k));
      end
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t d, input int k);
    dv_t         o;
    logic [61:0] t;
    o = d;
    t = {30'b0, d.len} << (DvSteps - 1 - k);
    if ({1'b0, d.ra} >= t) begin
      o.ra = d.ra - t[60:0];
      o.qa = d.qa | (30'd1 << (DvSteps - 1 - k));
    end
    if ({1'b0, d.rb} >= t) begin
      o.rb = d.rb - t[60:0];
      o.qb = d.qb | (30'd1 << (DvSteps - 1 - k));
    end
    return o;
  endfunction

  logic            adv;
  logic            iv;
  in_t             ireg;
  logic            v1, v2, v3, v4, v5;
  s1_t             s1, s1_next;
  s2_t             s2;
  s3_t             s3;
  s4_t             s4;
  s5_t             s5;
  logic [SqSteps:0] sqv;
  sq_t             sq [SqSteps+1];
  logic [DvSteps:0] dvv;
  dv_t             dv [DvSteps+1];
  logic            ev;
  em_t             em;
  logic [1:0]      cnt_c, cnt_sub, cnt_j;
  logic            fire, em_last;

  // input register
  assign prim_stall = iv && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (adv || !iv) begin
      iv <= prim_valid;
    end
    if (adv || !iv) begin
      ireg <= '{op: operation, sx: start_x, sy: start_y, ex: end_x, ey: end_y,
                ext: extent, thick: thickness, color: color};
    end
  end

  // front calculation
  logic signed [32:0] dx, dy;
  logic [29:0]        half;
  logic signed [33:0] lx, rx, ty, by;

  always_comb begin
    dx   = {ireg.ex[31], ireg.ex} - {ireg.sx[31], ireg.sx};
    dy   = {ireg.ey[31], ireg.ey} - {ireg.sy[31], ireg.sy};
    half = ireg.ext[30:1];
    lx   = {{2{ireg.sx[31]}}, ireg.sx} - {4'b0, half};
    rx   = {{2{ireg.sx[31]}}, ireg.sx} + {4'b0, half};
    ty   = {{2{ireg.sy[31]}}, ireg.sy} + {4'b0, half};
    by   = {{2{ireg.sy[31]}}, ireg.sy} - {4'b0, half};
    s1_next.a     = dx[32] ? (~dx + 33'd1) : dx;
    s1_next.b     = dy[32] ? (~dy + 33'd1) : dy;
    s1_next.h     = ireg.thick[30:1];
    s1_next.r2    = {1'b0, ireg.ext, 1'b0} + {2'b0, ireg.thick};
    s1_next.thick = ireg.thick;
    s1_next.p.op    = op_t'(ireg.op);
    s1_next.p.color = ireg.color;
    s1_next.p.negx  = dx[32];
    s1_next.p.negy  = dy[32];
    if (op_t'(ireg.op) == OP_BOX) begin
      s1_next.p.p0x = sat34(lx);
      s1_next.p.p0y = sat34(ty);
      s1_next.p.p1x = sat34(rx);
      s1_next.p.p1y = sat34(by);
    end else begin
      s1_next.p.p0x = ireg.sx;
      s1_next.p.p0y = ireg.sy;
      s1_next.p.p1x = ireg.ex;
      s1_next.p.p1y = ireg.ey;
    end
    case (op_t'(ireg.op))
      OP_CIRCLE: begin
        s1_next.p.rad  = s1_next.r2[32:1];
        s1_next.p.zero = 1'b0;
      end
      OP_SQUARE: begin
        s1_next.p.rad  = {1'b0, ireg.ext};
        s1_next.p.zero = 1'b0;
      end
      OP_LINE: begin
        s1_next.p.rad  = {2'b0, ireg.thick[30:1]};
        s1_next.p.zero = (dx == 33'sd0) && (dy == 33'sd0);
      end
      default: begin
        s1_next.p.rad  = {2'b0, ireg.thick[30:1]};
        s1_next.p.zero = (half == 30'd0);
      end
    endcase
  end

  // normalise, square, sum
  logic [5:0]  e_next;
  logic [30:0] an_next, bn_next;

  always_comb begin
    e_next = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (s2.m[i]) e_next = 6'(i);
    end
  end

  always_comb begin
    if (s3.e >= 6'd31) begin
      an_next = 31'(s3.a >> (s3.e - 6'd30));
      bn_next = 31'(s3.b >> (s3.e - 6'd30));
    end else begin
      an_next = 31'(s3.a << (6'd30 - s3.e));
      bn_next = 31'(s3.b << (6'd30 - s3.e));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= '{p: s1.p, a: s1.a, b: s1.b, m: (s1.a > s1.b) ? s1.a : s1.b,
              h: s1.h, r2: s1.r2, thick: s1.thick};
      s3 <= '{p: s2.p, a: s2.a, b: s2.b, e: e_next, h: s2.h, r2: s2.r2, thick: s2.thick};
      s4 <= '{p: s3.p, an: an_next, bn: bn_next, h: s3.h, r2: s3.r2, thick: s3.thick};
      s5 <= '{p: s4.p,
              sa: 62'(s4.an) * 62'(s4.an),
              sb: 62'(s4.bn) * 62'(s4.bn),
              na: 61'(s4.h) * 61'(s4.an),
              nb: 61'(s4.h) * 61'(s4.bn),
              r2: s4.r2, thick: s4.thick};
      sq[0] <= '{p: s5.p, s: {1'b0, 63'(s5.sa) + 63'(s5.sb)}, res: 64'd0,
                 na: s5.na, nb: s5.nb, brem: {s5.thick, 17'b0}, bden: s5.r2, bq: 18'd0};
      dv[0] <= '{p: sq[SqSteps].p, len: sq[SqSteps].res[31:0],
                 ra: sq[SqSteps].na, rb: sq[SqSteps].nb, qa: 30'd0, qb: 30'd0,
                 border: (sq[SqSteps].p.op == OP_CIRCLE && sq[SqSteps].bden != 33'd0)
                         ? sq[SqSteps].bq : 18'd0};
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) sq[k+1] <= sq_step(sq[k], k);
    end
  end

  for (genvar k = 0; k < DvSteps; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (adv) dv[k+1] <= dv_step(dv[k], k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
      sqv <= '0;
      dvv <= '0;
      ev  <= 1'b0;
    end else if (adv) begin
      v1  <= iv;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      sqv <= {sqv[SqSteps-1:0], v5};
      dvv <= {dvv[DvSteps-1:0], sqv[SqSteps]};
      ev  <= dvv[DvSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      em.p      <= dv[DvSteps].p;
      em.px     <= dv[DvSteps].p.negy ? -{2'b0, dv[DvSteps].qb} : {2'b0, dv[DvSteps].qb};
      em.py     <= dv[DvSteps].p.negx ? -{2'b0, dv[DvSteps].qa} : {2'b0, dv[DvSteps].qa};
      em.border <= dv[DvSteps].border;
    end
  end

  // vertex emitter
  logic signed [31:0] qsx, qsy, qex, qey, lpx, lpy, h32;
  logic signed [33:0] bx, by34, offx, offy, rad34, px34, py34;
  logic               cxpos, cypos, quad, knd;
  logic [17:0]        brd;

  always_comb begin
    h32   = em.p.rad;
    rad34 = {2'b0, em.p.rad};
    cxpos = (cnt_c == 2'd1) || (cnt_c == 2'd2);
    cypos = (cnt_c == 2'd0) || (cnt_c == 2'd1);
    qsx = em.p.p0x;
    qsy = em.p.p0y;
    qex = em.p.p1x;
    qey = em.p.p1y;
    lpx = em.px;
    lpy = em.py;
    if (em.p.op == OP_BOX) begin
      case (cnt_j)
        2'd0: begin
          qsx = em.p.p0x; qsy = em.p.p0y; qex = em.p.p1x; qey = em.p.p0y;
          lpx = 32'sd0;   lpy = h32;
        end
        2'd1: begin
          qsx = em.p.p1x; qsy = em.p.p0y; qex = em.p.p1x; qey = em.p.p1y;
          lpx = -h32;     lpy = 32'sd0;
        end
        2'd2: begin
          qsx = em.p.p1x; qsy = em.p.p1y; qex = em.p.p0x; qey = em.p.p1y;
          lpx = 32'sd0;   lpy = -h32;
        end
        default: begin
          qsx = em.p.p0x; qsy = em.p.p1y; qex = em.p.p0x; qey = em.p.p0y;
          lpx = h32;      lpy = 32'sd0;
        end
      endcase
    end
    px34 = {{2{lpx[31]}}, lpx};
    py34 = {{2{lpy[31]}}, lpy};
    quad = (em.p.op == OP_LINE || em.p.op == OP_BOX) && !em.p.zero && (cnt_sub == 2'd0);
    if (quad) begin
      bx   = cxpos ? {{2{qex[31]}}, qex} : {{2{qsx[31]}}, qsx};
      by34 = cxpos ? {{2{qey[31]}}, qey} : {{2{qsy[31]}}, qsy};
      offx = cypos ? -px34 : px34;
      offy = cypos ? py34 : -py34;
    end else begin
      if (em.p.op == OP_CIRCLE || em.p.op == OP_SQUARE || cnt_sub != 2'd2) begin
        bx   = {{2{qsx[31]}}, qsx};
        by34 = {{2{qsy[31]}}, qsy};
      end else begin
        bx   = {{2{qex[31]}}, qex};
        by34 = {{2{qey[31]}}, qey};
      end
      offx = cxpos ? rad34 : -rad34;
      offy = cypos ? rad34 : -rad34;
    end
    knd = (quad || em.p.op == OP_SQUARE) ? KIND_QUAD : KIND_POINT;
    brd = (em.p.op == OP_CIRCLE) ? em.border : 18'd0;
    case (em.p.op)
      OP_CIRCLE, OP_SQUARE: em_last = (cnt_c == 2'd3);
      OP_LINE:  em_last = (cnt_c == 2'd3) && (em.p.zero || cnt_sub == 2'd2);
      default:  em_last = (cnt_c == 2'd3) && (em.p.zero || cnt_sub == 2'd2) && (cnt_j == 2'd3);
    endcase
  end

  assign fire = ev && (!vert_valid || !vert_stall);
  assign adv  = !ev || (fire && em_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_c   <= 2'd0;
      cnt_sub <= 2'd0;
      cnt_j   <= 2'd0;
    end else if (fire) begin
      if (em_last) begin
        cnt_c   <= 2'd0;
        cnt_sub <= 2'd0;
        cnt_j   <= 2'd0;
      end else if (cnt_c == 2'd3) begin
        cnt_c <= 2'd0;
        if (em.p.zero || cnt_sub == 2'd2) begin
          cnt_sub <= 2'd0;
          cnt_j   <= cnt_j + 2'd1;
        end else begin
          cnt_sub <= cnt_sub + 2'd1;
        end
      end else begin
        cnt_c <= cnt_c + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
    end else if (fire) begin
      vert_valid <= 1'b1;
    end else if (!vert_stall) begin
      vert_valid <= 1'b0;
    end
    if (fire) begin
      vertex_kind  <= knd;
      vertex_x     <= sat34(bx + offx);
      vertex_y     <= sat34(by34 + offy);
      tex_u        <= CORNER_U[cnt_c];
      tex_v        <= CORNER_V[cnt_c];
      vertex_color <= em.p.color;
      border_ratio <= brd;
      last         <= em_last;
    end
  end

endmodule
`default_nettype wire

>>> src/pve_checker.sv
`default_nettype none
module pve_checker import pve_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               prim_valid,
  input wire logic               prim_stall,
  input wire logic [1:0]         operation,
  input wire logic signed [31:0] start_x,
  input wire logic signed [31:0] start_y,
  input wire logic signed [31:0] end_x,
  input wire logic signed [31:0] end_y,
  input wire logic [30:0]        extent,
  input wire logic [30:0]        thickness,
  input wire logic [31:0]        color,
  input wire logic               vert_valid,
  input wire logic               vert_stall,
  input wire logic               vertex_kind,
  input wire logic signed [31:0] vertex_x,
  input wire logic signed [31:0] vertex_y,
  input wire logic               tex_u,
  input wire logic               tex_v,
  input wire logic [31:0]        vertex_color,
  input wire logic [17:0]        border_ratio,
  input wire logic               last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_stall |=> vert_valid && $stable(vertex_x) && $stable(last))
    else $error("stalled vertex beat changed");

  a_quad_border: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vertex_kind == KIND_QUAD |-> border_ratio == 18'd0)
    else $error("quad vertex with nonzero border");

  a_border_max: assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> border_ratio <= 18'd131072)
    else $error("border above two");

  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    vert_valid && !tex_u && tex_v |-> !last)
    else $error("last on a first corner");

endmodule

bind primitive_to_vertex_expander pve_checker u_pve_checker (.*);
`default_nettype wire
